// File: hw/rtl/stt_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the source text tokenizer.
package stt_pkg;

    localparam int unsigned COL_W = 12;
    localparam int unsigned ROW_W = 16;
    localparam int unsigned ID_W  = 16;
    localparam int unsigned LEN_W = 12;

    localparam logic [LEN_W-1:0] LEN_CAP = 12'd4095;

    localparam logic [7:0] CH_ASSIGN = 8'h3d;
    localparam logic [7:0] CH_PLUS   = 8'h2b;
    localparam logic [7:0] CH_MINUS  = 8'h2d;
    localparam logic [7:0] CH_MUL    = 8'h2a;
    localparam logic [7:0] CH_DIV    = 8'h2f;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_NL     = 8'h0a;
    localparam logic [7:0] CH_UNDER  = 8'h5f;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_L      = 8'h6c;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_T      = 8'h74;

    // keyword match progress: 3 = "let" seen, 4 = no match
    localparam logic [2:0] KW_DONE = 3'd3;
    localparam logic [2:0] KW_NONE = 3'd4;

    typedef enum logic [3:0] {
        K_IDENT   = 4'd0,
        K_LET     = 4'd1,
        K_INT     = 4'd2,
        K_ASSIGN  = 4'd3,
        K_PLUS    = 4'd4,
        K_MINUS   = 4'd5,
        K_MUL     = 4'd6,
        K_DIV     = 4'd7,
        K_COLON   = 4'd8,
        K_ENDLINE = 4'd9,
        K_ERROR   = 4'd10,
        K_END     = 4'd11
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_IDENT  = 4'b0010,
        MODE_NUMBER = 4'b0100,
        MODE_DROP   = 4'b1000
    } t_mode;

    typedef struct packed {
        logic [3:0]       kind;
        logic [ID_W-1:0]  token_id;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic [LEN_W-1:0] length;
        logic             last;
    } t_result;

    function automatic logic [11:0] sat12(input logic [11:0] v, input logic [11:0] cap);
        return (v < cap) ? v + 12'd1 : cap;
    endfunction

    function automatic logic [15:0] sat16(input logic [15:0] v, input logic [15:0] cap);
        return (v < cap) ? v + 16'd1 : cap;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        logic [7:0] l;
        l = c | 8'h20;
        return (l >= 8'h61) && (l <= 8'h7a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic [2:0] kw_next(input logic [2:0] kw, input logic [7:0] c);
        logic [7:0] want;
        case (kw)
            3'd0:    want = CH_L;
            3'd1:    want = CH_E;
            default: want = CH_T;
        endcase
        return (kw < KW_DONE && c == want) ? kw + 3'd1 : KW_NONE;
    endfunction

endpackage

// File: hw/rtl/stt_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the tokenizer's character and token words.
interface stt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface stt_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  kind;
    logic [15:0] token_id;
    logic [15:0] row;
    logic [11:0] column;
    logic [11:0] length;
    logic        last;

    modport source (output valid, output kind, output token_id, output row,
                    output column, output length, output last, input ready);
    modport sink   (input valid, input kind, input token_id, input row,
                    input column, input length, input last, output ready);
endinterface

// File: hw/rtl/source_text_tokenizer_top.sv
`timescale 1ns / 1ps
// Source text tokenizer: scans one character word per cycle while i_in.ready is high, queues token words.
//
//  channel  dir  word                                        accepted when
//  i_in     in   char_code[7:0], last_char                   valid && ready
//  o_out    out  kind, token_id, row, column, length, last    valid && ready
//
// One character per cycle; the scanner state updates in the accepting cycle and
// up to three token words go into a four-entry output queue, drained one per cycle.
// i_in.ready is high while the queue holds at most one word, so input stalls only
// when the output side backs up or a character yields more than one token.
// Synchronous active-low reset clears the scanner and empties the queue.
module source_text_tokenizer_top #(
    parameter int unsigned MAX_COLUMN   = 4095,
    parameter int unsigned MAX_ROW      = 65535,
    parameter int unsigned MAX_TOKEN_ID = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    stt_in_if.sink      i_in,
    stt_out_if.source   o_out
);
    import stt_pkg::*;

    localparam logic [COL_W-1:0] COL_CAP = COL_W'((MAX_COLUMN < 4095) ? MAX_COLUMN : 4095);
    localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'((MAX_ROW < 65535) ? MAX_ROW : 65535);
    localparam logic [ID_W-1:0]  ID_CAP  =
        ID_W'((MAX_TOKEN_ID < 65535) ? MAX_TOKEN_ID : 65535);

    // scanner state
    t_mode            r_mode,  n_mode;
    logic [COL_W-1:0] r_start, n_start;
    logic [LEN_W-1:0] r_len,   n_len;
    logic [2:0]       r_kw,    n_kw;
    logic [ROW_W-1:0] r_row,   n_row;
    logic [COL_W-1:0] r_col,   n_col;
    logic [ID_W-1:0]  r_id,    n_id;

    // output queue
    t_result          r_q [4];
    logic [1:0]       r_head,  n_head;
    logic [2:0]       r_count, n_count;

    t_result          res [3];
    logic [1:0]       res_n;
    logic             used;
    logic             acc;
    logic             pop;
    logic [7:0]       c;
    logic             alnum;
    logic [1:0]       wp [3];

    assign c     = i_in.char_code;
    assign alnum = is_letter(c) || is_digit(c) || (c == CH_UNDER);
    assign i_in.ready = (r_count <= 3'd1);
    assign acc   = i_in.valid && i_in.ready;
    assign pop   = o_out.valid && o_out.ready;

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_kw    = r_kw;
        n_row   = r_row;
        n_col   = r_col;
        n_id    = r_id;
        res_n   = 2'd0;
        used    = (r_mode == MODE_DROP);
        for (int k = 0; k < 3; k++) begin
            res[k] = '0;
        end

        if (r_mode == MODE_IDENT || r_mode == MODE_NUMBER) begin
            if (alnum) begin
                n_len = sat12(r_len, LEN_CAP);
                if (r_mode == MODE_IDENT) begin
                    n_kw = kw_next(r_kw, c);
                end
                n_col = sat12(r_col, COL_CAP);
                used  = 1'b1;
            end else begin
                res[res_n].kind     = (r_mode == MODE_NUMBER) ? K_INT :
                                      (r_kw == KW_DONE) ? K_LET : K_IDENT;
                res[res_n].token_id = n_id;
                res[res_n].row      = r_row;
                res[res_n].column   = sat12(r_start, COL_CAP);
                res[res_n].length   = r_len;
                res_n  = res_n + 2'd1;
                n_id   = sat16(n_id, ID_CAP);
                n_mode = MODE_IDLE;
            end
        end

        if (!used) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                // blanks ahead of the first character of the text do not count
                if (!(r_row == ROW_W'(1) && r_col == '0)) begin
                    n_col = sat12(r_col, COL_CAP);
                end
            end else if (c == CH_NL) begin
                res[res_n].kind     = K_ENDLINE;
                res[res_n].token_id = n_id;
                res[res_n].row      = r_row;
                res[res_n].column   = sat12(r_col, COL_CAP);
                res[res_n].length   = LEN_W'(1);
                res_n = res_n + 2'd1;
                n_id  = sat16(n_id, ID_CAP);
                n_row = sat16(r_row, ROW_CAP);
                n_col = '0;
            end else if (is_letter(c) || is_digit(c)) begin
                n_mode  = is_letter(c) ? MODE_IDENT : MODE_NUMBER;
                n_start = r_col;
                n_len   = LEN_W'(1);
                n_kw    = is_letter(c) ? kw_next(3'd0, c) : 3'd0;
                n_col   = sat12(r_col, COL_CAP);
            end else if (c == CH_ASSIGN || c == CH_PLUS || c == CH_MINUS ||
                         c == CH_MUL || c == CH_DIV || c == CH_COLON) begin
                case (c)
                    CH_ASSIGN: res[res_n].kind = K_ASSIGN;
                    CH_PLUS:   res[res_n].kind = K_PLUS;
                    CH_MINUS:  res[res_n].kind = K_MINUS;
                    CH_MUL:    res[res_n].kind = K_MUL;
                    CH_DIV:    res[res_n].kind = K_DIV;
                    default:   res[res_n].kind = K_COLON;
                endcase
                res[res_n].token_id = n_id;
                res[res_n].row      = r_row;
                res[res_n].column   = sat12(r_col, COL_CAP);
                res[res_n].length   = LEN_W'(1);
                res_n = res_n + 2'd1;
                n_id  = sat16(n_id, ID_CAP);
                n_col = sat12(r_col, COL_CAP);
            end else begin
                res[res_n].kind     = K_ERROR;
                res[res_n].token_id = '0;
                res[res_n].row      = r_row;
                res[res_n].column   = r_col;
                res[res_n].length   = '0;
                res_n  = res_n + 2'd1;
                n_mode = MODE_DROP;
            end
        end

        if (i_in.last_char) begin
            if (n_mode == MODE_IDENT || n_mode == MODE_NUMBER) begin
                res[res_n].kind     = (n_mode == MODE_NUMBER) ? K_INT :
                                      (n_kw == KW_DONE) ? K_LET : K_IDENT;
                res[res_n].token_id = n_id;
                res[res_n].row      = n_row;
                res[res_n].column   = sat12(n_start, COL_CAP);
                res[res_n].length   = n_len;
                res_n = res_n + 2'd1;
            end
            res[res_n].kind     = K_END;
            res[res_n].token_id = '0;
            res[res_n].row      = n_row;
            res[res_n].column   = '0;
            res[res_n].length   = '0;
            res_n   = res_n + 2'd1;
            // back to the state of a fresh text
            n_mode  = MODE_IDLE;
            n_start = '0;
            n_len   = '0;
            n_kw    = 3'd0;
            n_row   = ROW_W'(1);
            n_col   = '0;
            n_id    = ID_W'(1);
        end

        for (int k = 0; k < 3; k++) begin
            res[k].last = (2'(k + 1) == res_n);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            wp[k] = r_head + r_count[1:0] + 2'(k);
        end
        n_head  = pop ? r_head + 2'd1 : r_head;
        n_count = r_count - {2'd0, pop} + (acc ? {1'b0, res_n} : 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_start <= '0;
            r_len   <= '0;
            r_kw    <= 3'd0;
            r_row   <= ROW_W'(1);
            r_col   <= '0;
            r_id    <= ID_W'(1);
            r_head  <= 2'd0;
            r_count <= 3'd0;
        end else begin
            if (acc) begin
                r_mode  <= n_mode;
                r_start <= n_start;
                r_len   <= n_len;
                r_kw    <= n_kw;
                r_row   <= n_row;
                r_col   <= n_col;
                r_id    <= n_id;
            end
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // queue payload, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (acc && 2'(k) < res_n) begin
                r_q[wp[k]] <= res[k];
            end
        end
    end

    assign o_out.valid    = (r_count != 3'd0);
    assign o_out.kind     = r_q[r_head].kind;
    assign o_out.token_id = r_q[r_head].token_id;
    assign o_out.row      = r_q[r_head].row;
    assign o_out.column   = r_q[r_head].column;
    assign o_out.length   = r_q[r_head].length;
    assign o_out.last     = r_q[r_head].last;

endmodule
